// ===== hdl/kot_pkg.sv =====
// Package for the keyword/operator tokenizer: token codes, state enums,
// queue entry type and character classification functions. No dependencies.
package kot_pkg;

    // token kinds
    localparam logic [5:0] KIND_EOF     = 6'd0;
    localparam logic [5:0] KIND_IDENT   = 6'd1;
    localparam logic [5:0] KIND_KW_BASE = 6'd2;
    localparam logic [5:0] KIND_MINUS   = 6'd16;
    localparam logic [5:0] KIND_PLUS    = 6'd17;
    localparam logic [5:0] KIND_STAR    = 6'd18;
    localparam logic [5:0] KIND_SLASH   = 6'd19;
    localparam logic [5:0] KIND_LPAREN  = 6'd20;
    localparam logic [5:0] KIND_RPAREN  = 6'd21;
    localparam logic [5:0] KIND_LBRACE  = 6'd22;
    localparam logic [5:0] KIND_RBRACE  = 6'd23;
    localparam logic [5:0] KIND_SEMI    = 6'd24;
    localparam logic [5:0] KIND_COMMA   = 6'd25;
    localparam logic [5:0] KIND_ASSIGN  = 6'd26;
    localparam logic [5:0] KIND_NONE    = 6'd63;

    // pending operator codes
    typedef enum logic [2:0] {
        PEND_NONE = 3'd0,
        PEND_BANG = 3'd1,
        PEND_LT   = 3'd2,
        PEND_GT   = 3'd3,
        PEND_AMP  = 3'd4,
        PEND_BAR  = 3'd5
    } pend_t;

    // back end states
    typedef enum logic [1:0] {
        BE_IDLE,
        BE_PEND,
        BE_WORD,
        BE_TAIL
    } be_state_t;

    // command from front to back
    typedef struct packed {
        logic [7:0] ch;       // raw byte
        logic       is_word;  // word character
        pend_t      pend;     // starts a pending operator
        logic [5:0] single;   // single operator kind or KIND_NONE
    } cmd_t;

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5f);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        k = KIND_NONE;
        case (c)
            8'h2d:   k = KIND_MINUS;
            8'h2b:   k = KIND_PLUS;
            8'h2a:   k = KIND_STAR;
            8'h2f:   k = KIND_SLASH;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7b:   k = KIND_LBRACE;
            8'h7d:   k = KIND_RBRACE;
            8'h3b:   k = KIND_SEMI;
            8'h2c:   k = KIND_COMMA;
            8'h3d:   k = KIND_ASSIGN;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic pend_t pend_code(input logic [7:0] c);
        pend_t p;
        p = PEND_NONE;
        case (c)
            8'h21:   p = PEND_BANG;
            8'h3c:   p = PEND_LT;
            8'h3e:   p = PEND_GT;
            8'h26:   p = PEND_AMP;
            8'h7c:   p = PEND_BAR;
            default: p = PEND_NONE;
        endcase
        return p;
    endfunction

    function automatic logic [5:0] pend_kind(input pend_t p);
        logic [5:0] k;
        k = KIND_NONE;
        case (p)
            PEND_BANG: k = 6'd27;
            PEND_LT:   k = 6'd29;
            PEND_GT:   k = 6'd31;
            PEND_AMP:  k = 6'd33;
            PEND_BAR:  k = 6'd35;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] pend_join(input pend_t p);
        logic [7:0] j;
        j = 8'h00;
        case (p)
            PEND_BANG, PEND_LT, PEND_GT: j = 8'h3d;
            PEND_AMP:  j = 8'h26;
            PEND_BAR:  j = 8'h7c;
            default:   j = 8'h00;
        endcase
        return j;
    endfunction

    // keyword match: up to the first six characters of a word and its length;
    // returns the keyword kind or KIND_NONE
    function automatic logic [5:0] kw_match(input logic [47:0] w, input logic [2:0] len);
        logic [5:0] k;
        k = KIND_NONE;
        case (len)
            3'd2:
            begin
                if (w[15:0] == {8'h66, 8'h69}) k = 6'd2;       // if
                if (w[15:0] == {8'h30, 8'h55}) k = 6'd14;      // U0
            end
            3'd3:
            begin
                if (w[23:0] == {8'h72, 8'h6f, 8'h66}) k = 6'd5;   // for
                if (w[23:0] == {8'h32, 8'h33, 8'h55}) k = 6'd8;   // U32
                if (w[23:0] == {8'h34, 8'h36, 8'h55}) k = 6'd9;   // U64
                if (w[23:0] == {8'h32, 8'h33, 8'h49}) k = 6'd10;  // I32
                if (w[23:0] == {8'h34, 8'h36, 8'h49}) k = 6'd11;  // I64
                if (w[23:0] == {8'h32, 8'h33, 8'h46}) k = 6'd12;  // F32
                if (w[23:0] == {8'h34, 8'h36, 8'h46}) k = 6'd13;  // F64
            end
            3'd4:
            begin
                if (w[31:0] == {8'h65, 8'h73, 8'h6c, 8'h65}) k = 6'd3;  // else
                if (w[31:0] == {8'h6c, 8'h6f, 8'h6f, 8'h62}) k = 6'd7;  // bool
                if (w[31:0] == {8'h65, 8'h74, 8'h79, 8'h42}) k = 6'd15; // Byte
            end
            3'd5:
            begin
                if (w[39:0] == {8'h65, 8'h6c, 8'h69, 8'h68, 8'h77}) k = 6'd4; // while
            end
            3'd6:
            begin
                if (w == {8'h6e, 8'h72, 8'h75, 8'h74, 8'h65, 8'h72}) k = 6'd6; // return
            end
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/kot_front.sv =====
// Front end of the tokenizer: accepts source bytes, classifies them and
// pushes commands into a two-entry queue. Depends on kot_pkg.
module kot_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    char_byte,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output kot_pkg::cmd_t cmd
);
    import kot_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       new_cmd;
    logic       push, pop;

    // classify the incoming byte
    always_comb
    begin
        new_cmd.ch      = char_byte;
        new_cmd.is_word = is_word_char(char_byte);
        new_cmd.pend    = pend_code(char_byte);
        new_cmd.single  = single_kind(char_byte);
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    // hold queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // store commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
`endif

endmodule

// ===== hdl/kot_back.sv =====
// Back end of the tokenizer: word buffer memory, pending operator, keyword
// match and result emission through an output register. Depends on kot_pkg.
module kot_back #(
    parameter int MAX_WORD = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  kot_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [5:0]    token_kind,
    output logic [7:0]    text_char,
    output logic          token_end,
    output logic          last
);
    import kot_pkg::*;

    localparam int AW = $clog2(MAX_WORD);
    localparam int LW = $clog2(MAX_WORD + 1);

    logic [7:0]    mem [MAX_WORD];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          rd_en;

    be_state_t     state_reg, state_next;
    pend_t         pend_reg, pend_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [47:0]   head_reg, head_next;
    cmd_t          cur_reg, cur_next;   // byte being carried out

    logic          ov_reg, ov_next;
    logic [5:0]    ok_reg, ok_next;
    logic [7:0]    oc_reg, oc_next;
    logic          oe_reg, oe_next;
    logic          ol_reg, ol_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          out_free;
    logic          take;
    logic [5:0]    kw;
    logic          full;

    assign out_free  = !ov_reg || out_ready;
    assign kw        = (len_reg <= LW'(6)) ? kw_match(head_reg, len_reg[2:0]) : KIND_NONE;
    assign full      = (len_reg == LW'(MAX_WORD));
    assign cmd_ready = (state_reg == BE_IDLE) && out_free;
    assign take      = cmd_valid && cmd_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BE_IDLE:
                if (take)
                begin
                    if (pend_reg != PEND_NONE)
                        state_next = BE_PEND;
                    else if (cmd.is_word && !full)
                        state_next = BE_IDLE;
                    else if (len_reg != '0)
                        state_next = BE_WORD;
                    else if (cmd.is_word)
                        state_next = BE_IDLE;
                    else
                        state_next = BE_TAIL;
                end
            BE_PEND:
                if (out_free)
                begin
                    if (cur_reg.ch == pend_join(pend_reg))
                        state_next = BE_IDLE;
                    else if (len_reg != '0 && (!cur_reg.is_word || full))
                        state_next = BE_WORD;
                    else if (cur_reg.is_word)
                        state_next = BE_IDLE;
                    else
                        state_next = BE_TAIL;
                end
            BE_WORD:
                if (out_free && (kw != KIND_NONE || idx_reg == len_reg))
                    state_next = cur_reg.is_word ? BE_IDLE : BE_TAIL;
            BE_TAIL:
                if (out_free)
                    state_next = BE_IDLE;
            default: state_next = BE_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pend_next = pend_reg;
        len_next  = len_reg;
        idx_next  = idx_reg;
        head_next = head_reg;
        cur_next  = cur_reg;
        ov_next   = ov_reg && !out_ready;
        ok_next   = ok_reg;
        oc_next   = oc_reg;
        oe_next   = oe_reg;
        ol_next   = ol_reg;
        wr_en     = 1'b0;
        wr_addr   = len_reg[AW-1:0];
        rd_en     = 1'b0;
        rd_addr   = '0;
        case (state_reg)
            BE_IDLE:
                if (take)
                begin
                    cur_next = cmd;
                    idx_next = '0;
                    rd_en    = 1'b1;
                    if (pend_reg == PEND_NONE && cmd.is_word && !full)
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + LW'(1);
                        if (len_reg < LW'(6))
                            head_next[len_reg[2:0]*8 +: 8] = cmd.ch;
                    end
                end
            BE_PEND:
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    oc_next   = 8'h00;
                    oe_next   = 1'b1;
                    pend_next = PEND_NONE;
                    rd_en     = 1'b1;
                    if (cur_reg.ch == pend_join(pend_reg))
                    begin
                        ok_next = pend_kind(pend_reg) + 6'd1;
                        ol_next = 1'b1;
                    end
                    else
                    begin
                        ok_next = pend_kind(pend_reg);
                        if (len_reg != '0 && (!cur_reg.is_word || full))
                            ol_next = 1'b0;
                        else if (cur_reg.is_word)
                        begin
                            ol_next  = 1'b1;
                            wr_en    = 1'b1;
                            len_next = len_reg + LW'(1);
                            if (len_reg < LW'(6))
                                head_next[len_reg[2:0]*8 +: 8] = cur_reg.ch;
                        end
                        else
                            ol_next = (cur_reg.ch != 8'h00) && (cur_reg.single == KIND_NONE);
                    end
                end
            BE_WORD:
                if (out_free)
                begin
                    ov_next = 1'b1;
                    if (kw != KIND_NONE || idx_reg == len_reg)
                    begin
                        // word done: keyword, or identifier tail already shown
                        idx_next = '0;
                        if (kw != KIND_NONE)
                        begin
                            ok_next = kw;
                            oc_next = 8'h00;
                            oe_next = 1'b1;
                        end
                        else
                            ov_next = ov_reg && !out_ready;
                        if (cur_reg.is_word)
                        begin
                            // full buffer: start the new word
                            wr_en     = 1'b1;
                            wr_addr   = '0;
                            len_next  = LW'(1);
                            head_next = {40'h0, cur_reg.ch};
                            if (kw != KIND_NONE)
                                ol_next = 1'b1;
                        end
                        else
                        begin
                            len_next = '0;
                            if (kw != KIND_NONE)
                                ol_next = (cur_reg.ch != 8'h00)
                                          && (cur_reg.single == KIND_NONE);
                        end
                    end
                    else
                    begin
                        // emit one identifier character
                        ok_next  = KIND_IDENT;
                        oc_next  = rd_data_reg;
                        oe_next  = (idx_reg + LW'(1) == len_reg);
                        ol_next  = oe_next && (cur_reg.is_word ||
                                   ((cur_reg.ch != 8'h00) && (cur_reg.single == KIND_NONE)));
                        idx_next = idx_reg + LW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_next[AW-1:0];
                    end
                end
            BE_TAIL:
                if (out_free)
                begin
                    if (cur_reg.ch == 8'h00)
                    begin
                        ov_next = 1'b1;
                        ok_next = KIND_EOF;
                        oc_next = 8'h00;
                        oe_next = 1'b1;
                        ol_next = 1'b1;
                    end
                    else if (cur_reg.pend != PEND_NONE)
                        pend_next = cur_reg.pend;
                    else if (cur_reg.single != KIND_NONE)
                    begin
                        ov_next = 1'b1;
                        ok_next = cur_reg.single;
                        oc_next = 8'h00;
                        oe_next = 1'b1;
                        ol_next = 1'b1;
                    end
                end
            default: ;
        endcase
    end

    // word buffer memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= (state_reg == BE_IDLE) ? cmd.ch : cur_reg.ch;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_IDLE;
            pend_reg  <= PEND_NONE;
            len_reg   <= '0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        cur_reg  <= cur_next;
        ok_reg   <= ok_next;
        oc_reg   <= oc_next;
        oe_reg   <= oe_next;
        ol_reg   <= ol_next;
    end

    assign out_valid  = ov_reg;
    assign token_kind = ok_reg;
    assign text_char  = oc_reg;
    assign token_end  = oe_reg;
    assign last       = ol_reg;

`ifndef SYNTH
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_WORD)) else $error("word length overflow");
    a_pend_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BE_IDLE && pend_reg != PEND_NONE) |-> len_reg == '0)
        else $error("pending operator with buffered word");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= len_reg) else $error("read index beyond word");
`endif

endmodule

// ===== hdl/keyword_operator_tokenizer_core.sv =====
// Keyword/operator tokenizer top level: front classifier, queue, back end.
// Bytes pass the queue and the back end state; results leave through the output register.
// Word characters keep the back end idle; other bytes, a pending operator
// or a flushed keyword or identifier keep it busy while the two-entry queue fills.
// Reset: asynchronous active low; clears queue, word length, pending operator.
// Depends on kot_pkg, kot_front, kot_back.
module keyword_operator_tokenizer_core #(
    parameter int MAX_WORD = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [5:0] token_kind,
    output logic [7:0] text_char,
    output logic       token_end,
    output logic       last
);
    import kot_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    // classify and queue
    kot_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // carry out and emit
    kot_back #(
        .MAX_WORD (MAX_WORD)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .token_kind (token_kind),
        .text_char  (text_char),
        .token_end  (token_end),
        .last       (last)
    );

endmodule
